/* rtl/gmse_pkg.sv */
// ----------------------------------------------------------------------------
// gmse_pkg
// Shared constants, types and tables for the green-masked Sobel edge map.
// ----------------------------------------------------------------------------
package gmse_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 1024;
  localparam int MEM_AW     = $clog2(MAX_WIDTH);
  localparam int MIN_SIZE   = 8;

  // register reset values
  localparam logic [11:0] RST_FRAME_WIDTH    = 12'd1280;
  localparam logic [10:0] RST_FRAME_HEIGHT   = 11'd720;
  localparam logic [7:0]  RST_GREEN_MARGIN   = 8'd10;
  localparam logic [10:0] RST_EDGE_THRESHOLD = 11'd30;

  // blur normalization: floor(s / 273) == (s * 122911) >> 25 for s < 123941
  localparam logic [16:0] GAUSS_RECIP = 17'd122911;
  localparam int          GAUSS_SHIFT = 25;

  localparam logic [5:0] GAUSS_W [5][5] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_GREEN_MARGIN   = 3'd2,
    CFG_EDGE_THRESHOLD = 3'd3
  } cfg_idx_e;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic        act;     // item runs one filter step
    logic        emit;    // item delivers a result beat
    logic        fend;
    logic [9:0]  orow;
    logic [10:0] ocol;
    logic [9:0]  tr;      // tap position
    logic [10:0] tc;
    logic [23:0] pix;
    logic [9:0]  gr;      // blur center position
    logic [10:0] gc;
    logic        g_in;
    logic        s_skip;
    logic        s_colz;
    logic        s_rowz;
  } ctl_t;

endpackage

/* rtl/green_masked_sobel_edge_map.sv */
// ----------------------------------------------------------------------------
// green_masked_sobel_edge_map
// 5x5 Gaussian blur, green mask and 3x3 Sobel edge decision on a BGR stream.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+---------------------------------
//  in      | in  | in_valid_i / in_stall_o   | mode_i, blue_i, green_i, red_i
//  out     | out | out_valid_o / out_stall_i | edge_res_o, pixel_row_o,
//          |     |                           | pixel_col_o, frame_end_o
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One beat per cycle when no output stall or clearing sweep holds the input;
//  the rate is set by the read-modify-write of the two line stores, each one
//  access per cycle. After reset both line stores are zeroed by a sweep over
//  all 2048 addresses, during which in_stall_o is high (cfg writes are taken).
//  A stalled output beat freezes the whole pipeline; in_stall_o follows.
//
module green_masked_sobel_edge_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        edge_res_o,
  output logic [9:0]  pixel_row_o,
  output logic [10:0] pixel_col_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int AW = gmse_pkg::MEM_AW;
  localparam int NS = 9;  // pipeline stages p1..p9

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [11:0] fw_q;
  logic [10:0] fh_q;
  logic [7:0]  margin_q;
  logic [10:0] thr_q;
  logic [21:0] t2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= gmse_pkg::RST_FRAME_WIDTH;
      fh_q     <= gmse_pkg::RST_FRAME_HEIGHT;
      margin_q <= gmse_pkg::RST_GREEN_MARGIN;
      thr_q    <= gmse_pkg::RST_EDGE_THRESHOLD;
    end else if (cfg_valid_i) begin
      case (gmse_pkg::cfg_idx_e'(cfg_index_i))
        gmse_pkg::CFG_FRAME_WIDTH:    fw_q     <= cfg_data_i;
        gmse_pkg::CFG_FRAME_HEIGHT:   fh_q     <= cfg_data_i[10:0];
        gmse_pkg::CFG_GREEN_MARGIN:   margin_q <= cfg_data_i[7:0];
        gmse_pkg::CFG_EDGE_THRESHOLD: thr_q    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // squared threshold, recomputed each cycle (the user moves cfg only while idle; the block does not enforce it)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_q <= 22'(gmse_pkg::RST_EDGE_THRESHOLD * gmse_pkg::RST_EDGE_THRESHOLD);
    end else begin
      t2_q <= 22'(thr_q) * 22'(thr_q);
    end
  end

  // saturated frame size
  logic [11:0] w_eff;
  logic [10:0] h_eff;
  logic [13:0] lag;

  always_comb begin
    if (fw_q < 12'(gmse_pkg::MIN_SIZE))       w_eff = 12'(gmse_pkg::MIN_SIZE);
    else if (fw_q > 12'(gmse_pkg::MAX_WIDTH)) w_eff = 12'(gmse_pkg::MAX_WIDTH);
    else                                      w_eff = fw_q;
    if (fh_q < 11'(gmse_pkg::MIN_SIZE))        h_eff = 11'(gmse_pkg::MIN_SIZE);
    else if (fh_q > 11'(gmse_pkg::MAX_HEIGHT)) h_eff = 11'(gmse_pkg::MAX_HEIGHT);
    else                                       h_eff = fh_q;
  end

  // results trail the taps by three rows and three pixels
  assign lag = {1'b0, w_eff, 1'b0} + {2'b0, w_eff} + 14'd3;

  logic signed [13:0] w_s, h_s;
  assign w_s = $signed({2'b0, w_eff});
  assign h_s = $signed({3'b0, h_eff});

  // --------------------------------------------------------------------------
  // reset clearing sweep of the line stores
  // --------------------------------------------------------------------------
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == {AW{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // handshake: the pipeline moves on adv
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv, accept;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv || clr_busy_q;
  assign accept     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // front end: positions and pending count
  // --------------------------------------------------------------------------
  logic [9:0]  in_row_q, out_row_q;
  logic [10:0] in_col_q, out_col_q;
  logic [12:0] pend_q;
  logic [13:0] pend_inc;
  gmse_pkg::ctl_t ctl0;

  logic [11:0] fl_c;
  logic [10:0] fl_r;

  // flush tap: output position plus the lag, wrapped in the frame
  always_comb begin
    fl_c = {1'b0, out_col_q} + 12'd3;
    fl_r = {1'b0, out_row_q} + 11'd3;
    if (fl_c >= w_eff) begin
      fl_c = fl_c - w_eff;
      fl_r = fl_r + 11'd1;
    end
    if (fl_r >= h_eff) begin
      fl_r = fl_r - h_eff;
    end
  end

  assign pend_inc = {1'b0, pend_q} + 14'd1;

  always_comb begin
    ctl0      = '0;
    ctl0.orow = out_row_q;
    ctl0.ocol = out_col_q;
    ctl0.fend = ({1'b0, out_row_q} == h_eff - 11'd1) && ({1'b0, out_col_q} == w_eff - 12'd1);
    ctl0.pix  = {red_i, green_i, blue_i};
    if (!mode_i) begin
      ctl0.act  = 1'b1;
      ctl0.emit = pend_inc > lag;
      ctl0.tr   = in_row_q;
      ctl0.tc   = in_col_q;
    end else begin
      ctl0.act  = pend_q != '0;
      ctl0.emit = pend_q != '0;
      ctl0.pix  = '0;
      ctl0.tr   = fl_r[9:0];
      ctl0.tc   = fl_c[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      pend_q    <= '0;
    end else if (accept) begin
      if (!mode_i) begin
        if ({1'b0, in_col_q} + 12'd1 >= w_eff) begin
          in_col_q <= '0;
          if ({1'b0, in_row_q} + 11'd1 >= h_eff) in_row_q <= '0;
          else                                   in_row_q <= in_row_q + 10'd1;
        end else begin
          in_col_q <= in_col_q + 11'd1;
        end
        if (ctl0.emit) pend_q <= lag[12:0];
        else           pend_q <= pend_inc[12:0];
      end else if (ctl0.act) begin
        pend_q <= pend_q - 13'd1;
      end
      if (ctl0.emit) begin
        if ({1'b0, out_col_q} + 12'd1 >= w_eff) begin
          out_col_q <= '0;
          if ({1'b0, out_row_q} + 11'd1 >= h_eff) out_row_q <= '0;
          else                                    out_row_q <= out_row_q + 10'd1;
        end else begin
          out_col_q <= out_col_q + 11'd1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  gmse_pkg::ctl_t pipe_q [NS];
  gmse_pkg::ctl_t pipe_d [NS];

  // p1: blur center position
  logic signed [13:0] gr_s, gc_s;
  logic               g_in;
  always_comb begin
    gc_s = $signed({3'b0, pipe_q[0].tc}) - 14'sd2;
    gr_s = $signed({4'b0, pipe_q[0].tr}) - 14'sd2;
    if (gc_s < 0) begin
      gc_s = gc_s + w_s;
      gr_s = gr_s - 14'sd1;
    end
    if (gr_s < 0) begin
      gr_s = gr_s + h_s;
    end
    g_in = (gr_s >= 14'sd2) && (gr_s <= h_s - 14'sd3) &&
           (gc_s >= 14'sd2) && (gc_s <= w_s - 14'sd3);
  end

  // p2: Sobel center position
  logic signed [13:0] sr_s, sc_s;
  always_comb begin
    sc_s = $signed({3'b0, pipe_q[1].gc}) - 14'sd1;
    sr_s = $signed({4'b0, pipe_q[1].gr}) - 14'sd1;
    if (sc_s < 0) begin
      sc_s = sc_s + w_s;
      sr_s = sr_s - 14'sd1;
    end
    if (sr_s < 0) begin
      sr_s = sr_s + h_s;
    end
  end

  always_comb begin
    pipe_d[0] = accept ? ctl0 : '0;
    for (int i = 1; i < NS; i++) begin
      pipe_d[i] = pipe_q[i-1];
    end
    pipe_d[1].gr     = gr_s[9:0];
    pipe_d[1].gc     = gc_s[10:0];
    pipe_d[1].g_in   = g_in;
    pipe_d[2].s_skip = (sr_s < 14'sd1) || (sc_s < 14'sd1);
    pipe_d[2].s_colz = sc_s >= w_s - 14'sd1;
    pipe_d[2].s_rowz = sr_s >= h_s - 14'sd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) pipe_q[i] <= '0;
    end else if (adv) begin
      for (int i = 0; i < NS; i++) pipe_q[i] <= pipe_d[i];
    end
  end

  // --------------------------------------------------------------------------
  // raw line store: four rows per column, read at accept, written back in p1
  // --------------------------------------------------------------------------
  logic          raw_re, raw_we, raw_pwe;
  logic [AW-1:0] raw_waddr;
  logic [95:0]   raw_wdata, raw_pword, raw_rdata, raw_word;
  logic          raw_hit_q;
  logic [95:0]   raw_fwd_q;
  logic [23:0]   colv [5];

  assign raw_re  = accept && ctl0.act;
  assign raw_pwe = adv && pipe_q[0].act;

  assign raw_word = raw_hit_q ? raw_fwd_q : raw_rdata;
  always_comb begin
    for (int k = 0; k < 4; k++) colv[k] = raw_word[24*k +: 24];
    colv[4] = pipe_q[0].pix;
  end
  assign raw_pword = {colv[4], colv[3], colv[2], colv[1]};

  assign raw_we    = clr_busy_q || raw_pwe;
  assign raw_waddr = clr_busy_q ? clr_cnt_q : pipe_q[0].tc[AW-1:0];
  assign raw_wdata = clr_busy_q ? '0 : raw_pword;

  // same column read while the previous beat writes it back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_hit_q <= 1'b0;
    end else if (adv) begin
      raw_hit_q <= raw_re && raw_pwe && (ctl0.tc[AW-1:0] == pipe_q[0].tc[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) raw_fwd_q <= raw_pword;
  end

  gmse_ram #(.DW(96), .AW(AW)) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (raw_we),
    .waddr_i (raw_waddr),
    .wdata_i (raw_wdata),
    .re_i    (raw_re),
    .raddr_i (ctl0.tc[AW-1:0]),
    .rdata_o (raw_rdata)
  );

  // 5x5 raw window, newest column at index 4
  logic [23:0] rwin_q [5][5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 5; r++)
        for (int c = 0; c < 5; c++) rwin_q[r][c] <= '0;
    end else if (adv && pipe_q[0].act) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) rwin_q[r][c] <= rwin_q[r][c+1];
        rwin_q[r][4] <= colv[r];
      end
    end
  end

  // --------------------------------------------------------------------------
  // blur: p2 row sums, p3 column sum, p4 reciprocal multiply
  // --------------------------------------------------------------------------
  logic [14:0] rs_d [3][5];
  logic [14:0] rs_q [3][5];
  logic [16:0] sum_d [3];
  logic [16:0] sum_q [3];
  logic [7:0]  q_q [3];
  logic [33:0] prod [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 5; r++) begin
        rs_d[k][r] = '0;
        for (int c = 0; c < 5; c++) begin
          rs_d[k][r] = rs_d[k][r] +
                       15'(15'(gmse_pkg::GAUSS_W[r][c]) * 15'(rwin_q[r][c][8*k +: 8]));
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = '0;
      for (int r = 0; r < 5; r++) sum_d[k] = sum_d[k] + 17'(rs_q[k][r]);
      prod[k] = 34'(sum_q[k]) * 34'(gmse_pkg::GAUSS_RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs_q  <= rs_d;
      sum_q <= sum_d;
      for (int k = 0; k < 3; k++) q_q[k] <= prod[k][gmse_pkg::GAUSS_SHIFT +: 8];
    end
  end

  // --------------------------------------------------------------------------
  // p5: green mask, masked store read issued
  // --------------------------------------------------------------------------
  logic        keep;
  logic [23:0] mp_q;

  assign keep = pipe_q[4].g_in &&
                ({1'b0, q_q[1]} > {1'b0, q_q[0]} + {1'b0, margin_q}) &&
                ({1'b0, q_q[1]} > {1'b0, q_q[2]} + {1'b0, margin_q});

  always_ff @(posedge clk_i) begin
    if (adv) mp_q <= keep ? {q_q[2], q_q[1], q_q[0]} : '0;
  end

  // --------------------------------------------------------------------------
  // masked line store: two rows per column, written back in p6
  // --------------------------------------------------------------------------
  logic          msk_re, msk_we, msk_pwe;
  logic [AW-1:0] msk_waddr;
  logic [47:0]   msk_wdata, msk_pword, msk_rdata, msk_word;
  logic          msk_hit_q;
  logic [47:0]   msk_fwd_q;
  logic [23:0]   mcol [3];

  assign msk_re  = adv && pipe_q[4].act;
  assign msk_pwe = adv && pipe_q[5].act;

  assign msk_word  = msk_hit_q ? msk_fwd_q : msk_rdata;
  assign mcol[0]   = msk_word[23:0];
  assign mcol[1]   = msk_word[47:24];
  assign mcol[2]   = mp_q;
  assign msk_pword = {mcol[2], mcol[1]};

  assign msk_we    = clr_busy_q || msk_pwe;
  assign msk_waddr = clr_busy_q ? clr_cnt_q : pipe_q[5].gc[AW-1:0];
  assign msk_wdata = clr_busy_q ? '0 : msk_pword;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msk_hit_q <= 1'b0;
    end else if (adv) begin
      msk_hit_q <= msk_re && msk_pwe &&
                   (pipe_q[4].gc[AW-1:0] == pipe_q[5].gc[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) msk_fwd_q <= msk_pword;
  end

  gmse_ram #(.DW(48), .AW(AW)) u_msk_ram (
    .clk_i   (clk_i),
    .we_i    (msk_we),
    .waddr_i (msk_waddr),
    .wdata_i (msk_wdata),
    .re_i    (msk_re),
    .raddr_i (pipe_q[4].gc[AW-1:0]),
    .rdata_o (msk_rdata)
  );

  // 3x3 masked window, newest column at index 2
  logic [23:0] mwin_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) mwin_q[r][c] <= '0;
    end else if (adv && pipe_q[5].act) begin
      for (int r = 0; r < 3; r++) begin
        mwin_q[r][0] <= mwin_q[r][1];
        mwin_q[r][1] <= mwin_q[r][2];
        mwin_q[r][2] <= mcol[r];
      end
    end
  end

  // --------------------------------------------------------------------------
  // p7 Sobel, p8 squared magnitude, p9 threshold
  // --------------------------------------------------------------------------
  logic signed [11:0] m [3][3][3];
  logic signed [11:0] gx_d [3], gy_d [3];
  logic signed [11:0] gx_q [3], gy_q [3];
  logic [20:0]        mag_q [3];
  logic [23:0]        sqx [3], sqy [3];
  logic               edge_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m[k][r][c] = $signed({4'b0, mwin_q[r][c][8*k +: 8]});
          // right column past the frame edge, bottom row past the last row
          if (c == 2 && pipe_q[6].s_colz) m[k][r][c] = '0;
          if (r == 2 && pipe_q[6].s_rowz) m[k][r][c] = '0;
        end
      end
      gx_d[k] = (m[k][0][2] + (m[k][1][2] <<< 1) + m[k][2][2]) -
                (m[k][0][0] + (m[k][1][0] <<< 1) + m[k][2][0]);
      gy_d[k] = (m[k][2][0] + (m[k][2][1] <<< 1) + m[k][2][2]) -
                (m[k][0][0] + (m[k][0][1] <<< 1) + m[k][0][2]);
      sqx[k] = 24'(gx_q[k] * gx_q[k]);
      sqy[k] = 24'(gy_q[k] * gy_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
      for (int k = 0; k < 3; k++) mag_q[k] <= sqx[k][20:0] + sqy[k][20:0];
    end
  end

  always_comb begin
    edge_d = !pipe_q[8].s_skip;
    for (int k = 0; k < 3; k++) begin
      if (!({1'b0, mag_q[k]} > t2_q)) edge_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic        edge_q, fend_q;
  logic [9:0]  row_q;
  logic [10:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pipe_q[8].emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && pipe_q[8].emit) begin
      edge_q <= edge_d;
      row_q  <= pipe_q[8].orow;
      col_q  <= pipe_q[8].ocol;
      fend_q <= pipe_q[8].fend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign edge_res_o  = edge_q;
  assign pixel_row_o = row_q;
  assign pixel_col_o = col_q;
  assign frame_end_o = fend_q;

endmodule

/* rtl/gmse_ram.sv */
// ----------------------------------------------------------------------------
// gmse_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gmse_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/gmse_checker.sv */
// ----------------------------------------------------------------------------
// gmse_checker
// Port-level checks for the green-masked Sobel edge map.
// ----------------------------------------------------------------------------
module gmse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        mode_i,
  input logic [7:0]  blue_i,
  input logic [7:0]  green_i,
  input logic [7:0]  red_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        edge_res_o,
  input logic [9:0]  pixel_row_o,
  input logic [10:0] pixel_col_o,
  input logic        frame_end_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [11:0] cfg_data_i
);

  // stalled output beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_row_o) && $stable(pixel_col_o) &&
      $stable(edge_res_o) && $stable(frame_end_o))
    else $error("stalled output payload changed");

  // store clearing sweep holds off input right after reset
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken during store clearing");

  // the last pixel of a frame sits at least at row 7, column 7
  a_frame_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> pixel_col_o >= 11'd7 && pixel_row_o >= 10'd7)
    else $error("frame end flagged at impossible position");

endmodule

bind green_masked_sobel_edge_map gmse_checker u_gmse_checker (.*);
